// ----- hw/rtl/hrp_pkg.sv -----
package hrp_pkg;

    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_LINE  = 2'd1;
    localparam logic [1:0] PH_NAME  = 2'd2;
    localparam logic [1:0] PH_VALUE = 2'd3;

    localparam logic [1:0] ST_COMPLETE  = 2'd0;
    localparam logic [1:0] ST_MALFORMED = 2'd1;
    localparam logic [1:0] ST_TOO_LARGE = 2'd2;

    localparam logic [1:0] KIND_NONE  = 2'd0;
    localparam logic [1:0] KIND_HOST  = 2'd1;
    localparam logic [1:0] KIND_CLEN  = 2'd2;
    localparam logic [1:0] KIND_TENC  = 2'd3;

    localparam logic [2:0] SET_ROUTE = 3'd0;
    localparam logic [2:0] SET_VER   = 3'd1;
    localparam logic [2:0] SET_NAME  = 3'd2;
    localparam logic [2:0] SET_HOST  = 3'd3;
    localparam logic [2:0] SET_ZERO  = 3'd4;

    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_C     = 8'h63;
    localparam logic [23:0] CRLFCR  = 24'h0D0A0D;

    localparam logic [15:0] CFG_RESET = 16'd8192;
    localparam int POS_W = 7;
    localparam logic [55:0] CHUNK_STR = "chunked";

    typedef struct packed {
        logic [1:0]       phase;
        logic [1:0]       rl;
        logic [1:0]       vlive;
        logic             vheld;
        logic [5:0]       rvec;
        logic [2:0]       rheld;
        logic [POS_W-1:0] fpos;
        logic [2:0]       nmatch;
        logic [1:0]       kind;
        logic [3:0]       vflags;
        logic [1:0]       trim;
        logic [2:0]       cpos;
        logic             cfound;
        logic             bad;
        logic             host;
        logic             hostok;
        logic             body;
        logic             chunk;
    } pstate_t;

    typedef struct packed {
        logic [1:0]  parse_status;
        logic [2:0]  route_code;
        logic        version_minor;
        logic        host_present;
        logic        host_allowed;
        logic        body_present;
        logic        chunked_present;
        logic [15:0] header_length;
    } result_t;

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
    endfunction

    function automatic logic [135:0] pat_str(input logic [2:0] set, input logic [2:0] idx);
        logic [135:0] s;
        s = '0;
        case (set)
            SET_ROUTE:
                case (idx)
                    3'd0: s = "/";
                    3'd1: s = "/app.js";
                    3'd2: s = "/style.css";
                    3'd3: s = "/api/v1/health";
                    3'd4: s = "/api/v1/snapshot";
                    3'd5: s = "/api/v1/events";
                    default: s = '0;
                endcase
            SET_VER: s = (idx == 3'd0) ? 136'("HTTP/1.0") : 136'("HTTP/1.1");
            SET_NAME:
                case (idx)
                    3'd0: s = "host";
                    3'd1: s = "content-length";
                    3'd2: s = "transfer-encoding";
                    default: s = '0;
                endcase
            SET_HOST:
                case (idx)
                    3'd0: s = "127.0.0.1";
                    3'd1: s = "127.0.0.1:32123";
                    3'd2: s = "localhost";
                    3'd3: s = "localhost:32123";
                    default: s = '0;
                endcase
            SET_ZERO: s = "0";
            default: s = '0;
        endcase
        return s;
    endfunction

    function automatic logic [4:0] pat_len(input logic [2:0] set, input logic [2:0] idx);
        logic [4:0] n;
        n = '0;
        case (set)
            SET_ROUTE:
                case (idx)
                    3'd0: n = 5'd1;
                    3'd1: n = 5'd7;
                    3'd2: n = 5'd10;
                    3'd3: n = 5'd14;
                    3'd4: n = 5'd16;
                    3'd5: n = 5'd14;
                    default: n = '0;
                endcase
            SET_VER: n = 5'd8;
            SET_NAME:
                case (idx)
                    3'd0: n = 5'd4;
                    3'd1: n = 5'd14;
                    3'd2: n = 5'd17;
                    default: n = '0;
                endcase
            SET_HOST: n = (idx[0]) ? 5'd15 : 5'd9;
            SET_ZERO: n = 5'd1;
            default: n = '0;
        endcase
        return n;
    endfunction

    function automatic logic pat_hit(input logic [2:0] set, input logic [2:0] idx,
                                     input logic [POS_W-1:0] pos, input logic [7:0] c);
        logic [135:0] s;
        logic [4:0]   n;
        logic [7:0]   ch;
        s  = pat_str(set, idx);
        n  = pat_len(set, idx);
        ch = '0;
        if (POS_W'(n) > pos)
            ch = s[8*(int'(n) - 1 - int'(pos)) +: 8];
        return (POS_W'(n) > pos) && (ch == c);
    endfunction

    function automatic logic [7:0] chunk_char(input logic [2:0] p);
        return (p < 3'd7) ? CHUNK_STR[8*(6 - int'(p)) +: 8] : CH_C;
    endfunction

endpackage

// ----- hw/rtl/hrp_if.sv -----
interface hrp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       start_of_request;
    modport source (output valid, data_byte, start_of_request, input ready);
    modport sink (input valid, data_byte, start_of_request, output ready);
endinterface

interface hrp_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  parse_status;
    logic [2:0]  route_code;
    logic        version_minor;
    logic        host_present;
    logic        host_allowed;
    logic        body_present;
    logic        chunked_present;
    logic [15:0] header_length;
    modport source (output valid, parse_status, route_code, version_minor, host_present,
                    host_allowed, body_present, chunked_present, header_length,
                    input ready);
    modport sink (input valid, parse_status, route_code, version_minor, host_present,
                  host_allowed, body_present, chunked_present, header_length,
                  output ready);
endinterface

interface hrp_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] max_header_bytes;
    modport source (output valid, max_header_bytes, input ready);
    modport sink (input valid, max_header_bytes, output ready);
endinterface

// ----- hw/rtl/hrp_parse_core.sv -----
module hrp_parse_core #(
    parameter int HEADER_LIMIT = 65535,
    parameter int MATCH_WINDOW = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  accept,
    input  logic [7:0]            data_byte,
    input  logic                  start_of_request,
    input  logic [15:0]           max_header_bytes,
    output logic                  res_valid,
    output hrp_pkg::result_t      res
);
    import hrp_pkg::*;

    localparam int CW    = $clog2(HEADER_LIMIT + 2);
    localparam int CMP_W = (CW > 16) ? CW : 16;

    pstate_t          st_reg, st_next, s0, s1, s2, s_line;
    logic [CW-1:0]    cnt_reg, cnt_next, cnt_base, cnt_inc;
    logic [23:0]      rec_reg, rec_next, rec_base;
    logic [CMP_W-1:0] lim;

    function automatic logic [5:0] mstep(input logic [5:0] live, input logic [2:0] set,
                                         input int n, input logic [POS_W-1:0] pos,
                                         input logic [7:0] c);
        logic [5:0] r;
        r = live;
        if (pos >= POS_W'(MATCH_WINDOW))
            r = '0;
        else
            for (int i = 0; i < 6; i++)
                if (i < n && r[i] && !pat_hit(set, 3'(i), pos, c))
                    r[i] = 1'b0;
        return r;
    endfunction

    function automatic logic [2:0] mdone(input logic [5:0] live, input logic [2:0] set,
                                         input int n, input logic [POS_W-1:0] pos);
        logic [2:0] r;
        r = '0;
        for (int i = 5; i >= 0; i--)
            if (i < n && live[i] && POS_W'(pat_len(set, 3'(i))) == pos)
                r = 3'(i + 1);
        return r;
    endfunction

    function automatic logic [POS_W-1:0] bump(input logic [POS_W-1:0] p);
        return (p < POS_W'(MATCH_WINDOW)) ? p + 1'b1 : p;
    endfunction

    function automatic pstate_t take_char(input pstate_t s, input logic [7:0] c);
        pstate_t    n;
        logic [7:0] l;
        logic [2:0] k;
        n = s;
        l = to_lower(c);
        k = '0;
        case (s.phase)
            PH_LINE: begin
                if (c == CH_SP)
                begin
                    if (s.rl < 2'd2 && s.fpos == '0)
                        n.bad = 1'b1;
                    if (s.rl == 2'd1)
                        n.rheld = mdone(s.rvec, SET_ROUTE, 6, s.fpos);
                    if (s.rl >= 2'd2)
                        n.bad = 1'b1;
                    if (s.rl < 2'd3)
                        n.rl = s.rl + 2'd1;
                    n.fpos  = '0;
                    n.rvec  = 6'h3F;
                    n.vlive = 2'b11;
                end
                else
                begin
                    if (s.rl < 2'd2 && (c == CH_TAB || c == CH_CR || c == CH_LF))
                        n.bad = 1'b1;
                    if (s.rl == 2'd1)
                        n.rvec = mstep(s.rvec, SET_ROUTE, 6, s.fpos, c);
                    else if (s.rl == 2'd2)
                        n.vlive = 2'(mstep({4'b0, s.vlive}, SET_VER, 2, s.fpos, c));
                    n.fpos = bump(s.fpos);
                end
            end
            PH_NAME: begin
                if (c == CH_COLON)
                begin
                    k        = mdone({3'b0, s.nmatch}, SET_NAME, 3, s.fpos);
                    n.kind   = k[1:0];
                    n.phase  = PH_VALUE;
                    n.fpos   = '0;
                    n.trim   = 2'd0;
                    n.vflags = (k[1:0] == KIND_HOST) ? 4'hF : 4'h1;
                    n.cpos   = '0;
                    n.cfound = 1'b0;
                end
                else
                begin
                    n.nmatch = 3'(mstep({3'b0, s.nmatch}, SET_NAME, 3, s.fpos, l));
                    n.fpos   = bump(s.fpos);
                end
            end
            PH_VALUE: begin
                if (l == chunk_char(s.cpos))
                begin
                    n.cpos = s.cpos + 3'd1;
                    if (s.cpos == 3'd6)
                    begin
                        n.cfound = 1'b1;
                        n.cpos   = '0;
                    end
                end
                else
                    n.cpos = (l == CH_C) ? 3'd1 : 3'd0;
                if (c == CH_SP || c == CH_TAB)
                begin
                    if (s.trim == 2'd1)
                        n.trim = 2'd2;
                end
                else if (s.trim >= 2'd2)
                begin
                    n.trim   = 2'd3;
                    n.vflags = '0;
                end
                else
                begin
                    n.trim = 2'd1;
                    if (s.kind == KIND_HOST)
                        n.vflags = 4'(mstep({2'b0, s.vflags}, SET_HOST, 4, s.fpos, l));
                    else
                        n.vflags = 4'(mstep({2'b0, s.vflags}, SET_ZERO, 1, s.fpos, l));
                    n.fpos = bump(s.fpos);
                end
            end
            default: ;
        endcase
        return n;
    endfunction

    function automatic pstate_t end_line(input pstate_t s);
        pstate_t    n;
        logic [2:0] v;
        n = s;
        v = '0;
        case (s.phase)
            PH_LINE: begin
                if (s.rl != 2'd2)
                    n.bad = 1'b1;
                else
                begin
                    v = mdone({4'b0, s.vlive}, SET_VER, 2, s.fpos);
                    if (v == 3'd0)
                        n.bad = 1'b1;
                    else
                        n.vheld = (v == 3'd2);
                end
            end
            PH_NAME: n.bad = 1'b1;
            PH_VALUE: begin
                if (s.kind == KIND_HOST)
                begin
                    n.host   = 1'b1;
                    n.hostok = (mdone({2'b0, s.vflags}, SET_HOST, 4, s.fpos) != 3'd0);
                end
                else if (s.kind == KIND_CLEN)
                    n.body = (mdone({2'b0, s.vflags}, SET_ZERO, 1, s.fpos) == 3'd0);
                else if (s.kind == KIND_TENC)
                    n.chunk = s.cfound;
            end
            default: ;
        endcase
        n.phase  = PH_NAME;
        n.fpos   = '0;
        n.nmatch = 3'b111;
        return n;
    endfunction

    function automatic pstate_t cleared(input logic [1:0] ph);
        pstate_t n;
        n       = '0;
        n.phase = ph;
        n.vlive = 2'b11;
        n.rvec  = 6'h3F;
        return n;
    endfunction

    assign lim = (CMP_W'(max_header_bytes) < CMP_W'(HEADER_LIMIT)) ?
                 CMP_W'(max_header_bytes) : CMP_W'(HEADER_LIMIT);

    always_comb
    begin
        s0       = start_of_request ? cleared(PH_LINE) : st_reg;
        cnt_base = start_of_request ? '0 : cnt_reg;
        rec_base = start_of_request ? '0 : rec_reg;
        cnt_inc  = (cnt_base <= CW'(HEADER_LIMIT)) ? cnt_base + 1'b1 : cnt_base;
        // a CR held from the last byte is taken now unless it starts CRLF
        s_line   = end_line(s0);
        s1       = (rec_base[7:0] == CH_CR) ? take_char(s0, CH_CR) : s0;
        s2       = (data_byte != CH_CR) ? take_char(s1, data_byte) : s1;

        st_next   = st_reg;
        cnt_next  = cnt_reg;
        rec_next  = rec_reg;
        res_valid = 1'b0;
        res       = '0;
        if (accept && s0.phase != PH_IDLE)
        begin
            cnt_next = cnt_inc;
            rec_next = {rec_base[15:0], data_byte};
            if (CMP_W'(cnt_inc) > lim)
            begin
                st_next          = s0;
                st_next.phase    = PH_IDLE;
                res_valid        = 1'b1;
                res.parse_status = ST_TOO_LARGE;
            end
            else if (data_byte == CH_LF && rec_base == CRLFCR)
            begin
                st_next       = s0;
                st_next.phase = PH_IDLE;
                res_valid     = 1'b1;
                if (s0.bad)
                    res.parse_status = ST_MALFORMED;
                else
                begin
                    res.parse_status     = ST_COMPLETE;
                    res.route_code       = s0.rheld;
                    res.version_minor    = s0.vheld;
                    res.host_present     = s0.host;
                    res.host_allowed     = s0.host ? s0.hostok : !s0.vheld;
                    res.body_present     = s0.body;
                    res.chunked_present  = s0.chunk;
                    res.header_length    = 16'(cnt_inc);
                end
            end
            else if (data_byte == CH_LF && rec_base[7:0] == CH_CR)
                st_next = s_line;
            else
                st_next = s2;
        end
        else if (accept)
            st_next = s0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg  <= cleared(PH_IDLE);
            cnt_reg <= '0;
            rec_reg <= '0;
        end
        else
        begin
            st_reg  <= st_next;
            cnt_reg <= cnt_next;
            rec_reg <= rec_next;
        end
    end

endmodule

// ----- hw/rtl/hrp_out_buf.sv -----
module hrp_out_buf (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  hrp_pkg::result_t din,
    output logic             space,
    output logic             out_valid,
    input  logic             out_ready,
    output hrp_pkg::result_t dout
);
    import hrp_pkg::*;

    logic    out_valid_reg, skid_valid_reg;
    result_t out_reg, skid_reg;
    logic    pop;

    assign pop       = out_valid_reg && out_ready;
    assign space     = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign dout      = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
        end
        else if (push)
        begin
            if (!out_valid_reg || pop)
                out_valid_reg <= 1'b1;
            else
                skid_valid_reg <= 1'b1;
        end
        else if (pop)
            out_valid_reg <= 1'b0;
    end

    // payload: skid into output on pop; new item to output, or to skid if stalled
    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
                out_reg <= skid_reg;
        end
        else if (push)
        begin
            if (!out_valid_reg || pop)
                out_reg <= din;
            else
                skid_reg <= din;
        end
    end

endmodule

// ----- hw/rtl/http_request_header_parser.sv -----
// A result item is registered in the output buffer before it appears on rsp; it waits behind an earlier untaken item.
// Throughput: one byte per cycle while req.ready is high; all per-byte work is one pass of compare logic.
// A two-entry result buffer keeps bytes flowing while a result waits; req.ready
// drops only when both entries hold results.
// Reset: rst_n (async, active low) idles the parser until a start byte and sets
// max_header_bytes to 8192.
module http_request_header_parser #(
    parameter int HEADER_LIMIT = 65535,
    parameter int MATCH_WINDOW = 32
) (
    input logic        clk,
    input logic        rst_n,
    hrp_byte_if.sink   req,
    hrp_result_if.source rsp,
    hrp_cfg_if.sink    cfg
);
    import hrp_pkg::*;

    logic [15:0] max_reg;
    logic        space, accept, res_valid;
    result_t     res, dout;

    assign cfg.ready = 1'b1;
    assign req.ready = space;
    assign accept    = req.valid && space;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_reg <= CFG_RESET;
        else if (cfg.valid)
            max_reg <= cfg.max_header_bytes;
    end

    hrp_parse_core #(
        .HEADER_LIMIT (HEADER_LIMIT),
        .MATCH_WINDOW (MATCH_WINDOW)
    ) u_core (
        .clk              (clk),
        .rst_n            (rst_n),
        .accept           (accept),
        .data_byte        (req.data_byte),
        .start_of_request (req.start_of_request),
        .max_header_bytes (max_reg),
        .res_valid        (res_valid),
        .res              (res)
    );

    hrp_out_buf u_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .din       (res),
        .space     (space),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .dout      (dout)
    );

    assign rsp.parse_status     = dout.parse_status;
    assign rsp.route_code       = dout.route_code;
    assign rsp.version_minor    = dout.version_minor;
    assign rsp.host_present     = dout.host_present;
    assign rsp.host_allowed     = dout.host_allowed;
    assign rsp.body_present     = dout.body_present;
    assign rsp.chunked_present  = dout.chunked_present;
    assign rsp.header_length    = dout.header_length;

endmodule

// ----- hw/rtl/hrp_checker.sv -----
module hrp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic [1:0]  parse_status,
    input logic [2:0]  route_code,
    input logic        version_minor,
    input logic        host_present,
    input logic        host_allowed,
    input logic        body_present,
    input logic        chunked_present,
    input logic [15:0] header_length
);
    import hrp_pkg::*;

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("result dropped while stalled");

    a_hold_status: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> $stable(parse_status))
        else $error("stalled result changed");

    a_fail_clear: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && parse_status != ST_COMPLETE |->
        route_code == 3'd0 && !version_minor && !host_present && !host_allowed &&
        !body_present && !chunked_present && header_length == 16'd0)
        else $error("failed result carries fields");

    a_host_default: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && parse_status == ST_COMPLETE && !host_present |->
        host_allowed == !version_minor)
        else $error("host default wrong");

    a_min_length: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && parse_status == ST_COMPLETE |-> header_length >= 16'd4)
        else $error("complete header too short");

endmodule

bind http_request_header_parser hrp_checker u_chk (
    .clk              (clk),
    .rst_n            (rst_n),
    .rsp_valid        (rsp.valid),
    .rsp_ready        (rsp.ready),
    .parse_status     (rsp.parse_status),
    .route_code       (rsp.route_code),
    .version_minor    (rsp.version_minor),
    .host_present     (rsp.host_present),
    .host_allowed     (rsp.host_allowed),
    .body_present     (rsp.body_present),
    .chunked_present  (rsp.chunked_present),
    .header_length    (rsp.header_length)
);

// ----- bench/hrp_tb_pkg.sv -----
package hrp_tb_pkg;
    import hrp_pkg::*;

    class parse_scoreboard;
        result_t pending[$];
        int      errors;
        // predictor state
        logic [15:0] limit_reg;
        int unsigned count;
        logic [23:0] last3;
        logic [1:0]  phase;
        int unsigned rl_fld;
        logic [1:0]  ver_live;
        logic        ver_held;
        logic [5:0]  route_vec;
        logic [2:0]  route_held;
        int unsigned fpos;
        logic [2:0]  name_vec;
        logic [1:0]  kind;
        logic [3:0]  vflags;
        int unsigned trim;
        int unsigned cpos;
        bit          cfound;
        bit          bad, host, hostok, body, chunk;

        function new();
            errors = 0;
            limit_reg = CFG_RESET;
            clear();
            phase = PH_IDLE;
        endfunction

        function void clear();
            count = 0; last3 = '0; rl_fld = 0; ver_live = 2'b11; ver_held = 0;
            route_vec = 6'h3F; route_held = 0; fpos = 0; name_vec = 0; kind = KIND_NONE;
            vflags = 0; trim = 0; cpos = 0; cfound = 0;
            bad = 0; host = 0; hostok = 0; body = 0; chunk = 0;
        endfunction

        function string pat(int set, int i);
            string r[6] = '{"/", "/app.js", "/style.css", "/api/v1/health",
                            "/api/v1/snapshot", "/api/v1/events"};
            string v[2] = '{"HTTP/1.0", "HTTP/1.1"};
            string n[3] = '{"host", "content-length", "transfer-encoding"};
            string h[4] = '{"127.0.0.1", "127.0.0.1:32123", "localhost", "localhost:32123"};
            case (set)
                0: return r[i];
                1: return v[i];
                2: return n[i];
                3: return h[i];
                default: return "0";
            endcase
        endfunction

        function int unsigned narrow(int unsigned live, int set, int num,
                                     int unsigned pos, byte unsigned c);
            string s;
            if (pos >= 32) return 0;
            for (int i = 0; i < num; i++) begin
                s = pat(set, i);
                if (live[i] && (pos >= s.len() || byte'(s[pos]) != c)) live[i] = 0;
            end
            return live;
        endfunction

        function int unsigned settle(int unsigned live, int set, int num, int unsigned pos);
            for (int i = 0; i < num; i++)
                if (live[i] && pat(set, i).len() == pos) return i + 1;
            return 0;
        endfunction

        function byte unsigned lower(byte unsigned c);
            return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
        endfunction

        function void advance_pos();
            if (fpos < 32) fpos++;
        endfunction

        function void take_char(byte unsigned c);
            string cw = "chunked";
            byte unsigned l;
            if (phase == PH_LINE) begin
                if (c == CH_SP) begin
                    if (rl_fld < 2 && fpos == 0) bad = 1;
                    if (rl_fld == 1) route_held = 3'(settle(32'(route_vec), 0, 6, fpos));
                    if (rl_fld >= 2) bad = 1;
                    if (rl_fld < 3) rl_fld++;
                    fpos = 0; route_vec = 6'h3F; ver_live = 2'b11;
                end
                else begin
                    if (rl_fld < 2 && (c == CH_TAB || c == CH_CR || c == CH_LF)) bad = 1;
                    if (rl_fld == 1) route_vec = 6'(narrow(32'(route_vec), 0, 6, fpos, c));
                    else if (rl_fld == 2) ver_live = 2'(narrow(32'(ver_live), 1, 2, fpos, c));
                    advance_pos();
                end
            end
            else if (phase == PH_NAME) begin
                if (c == CH_COLON) begin
                    kind = 2'(settle(32'(name_vec), 2, 3, fpos));
                    phase = PH_VALUE; fpos = 0; trim = 0;
                    vflags = (kind == KIND_HOST) ? 4'hF : 4'h1;
                    cpos = 0; cfound = 0;
                end
                else begin
                    name_vec = 3'(narrow(32'(name_vec), 2, 3, fpos, lower(c)));
                    advance_pos();
                end
            end
            else if (phase == PH_VALUE) begin
                l = lower(c);
                if (l == byte'(cw[cpos])) begin
                    cpos++;
                    if (cpos >= 7) begin cfound = 1; cpos = 0; end
                end
                else cpos = (l == CH_C) ? 1 : 0;
                if (c == CH_SP || c == CH_TAB) begin
                    if (trim == 1) trim = 2;
                end
                else if (trim >= 2) begin
                    trim = 3; vflags = 0;
                end
                else begin
                    trim = 1;
                    if (kind == KIND_HOST) vflags = 4'(narrow(32'(vflags), 3, 4, fpos, l));
                    else vflags = 4'(narrow(32'(vflags), 4, 1, fpos, l));
                    advance_pos();
                end
            end
        endfunction

        function void end_line();
            int unsigned v;
            if (phase == PH_LINE) begin
                if (rl_fld != 2) bad = 1;
                else begin
                    v = settle(32'(ver_live), 1, 2, fpos);
                    if (v == 0) bad = 1;
                    else ver_held = 1'(v - 1);
                end
            end
            else if (phase == PH_NAME) bad = 1;
            else if (phase == PH_VALUE) begin
                if (kind == KIND_HOST) begin
                    host = 1;
                    hostok = settle(32'(vflags), 3, 4, fpos) != 0;
                end
                else if (kind == KIND_CLEN) body = settle(32'(vflags), 4, 1, fpos) == 0;
                else if (kind == KIND_TENC) chunk = cfound;
            end
            phase = PH_NAME; fpos = 0; name_vec = 3'b111;
        endfunction

        function void write_limit(logic [15:0] v);
            limit_reg = v;
        endfunction

        // note one accepted byte
        function void note_byte(byte unsigned c, bit sor);
            result_t r;
            if (sor) begin clear(); phase = PH_LINE; end
            if (phase == PH_IDLE) return;
            if (count <= 65535) count++;
            r = '0;
            if (count > limit_reg) begin
                r.parse_status = ST_TOO_LARGE;
                phase = PH_IDLE;
                pending.insert(pending.size(), r);
                return;
            end
            if (c == CH_LF && last3 == CRLFCR) begin
                phase = PH_IDLE;
                if (bad) r.parse_status = ST_MALFORMED;
                else begin
                    r.parse_status = ST_COMPLETE;
                    r.route_code = route_held;
                    r.version_minor = ver_held;
                    r.host_present = host;
                    r.host_allowed = host ? hostok : !ver_held;
                    r.body_present = body;
                    r.chunked_present = chunk;
                    r.header_length = count[15:0];
                end
                pending.insert(pending.size(), r);
                return;
            end
            if (c == CH_LF && last3[7:0] == CH_CR) end_line();
            else begin
                if (last3[7:0] == CH_CR) take_char(CH_CR);
                if (c != CH_CR) take_char(c);
            end
            last3 = {last3[15:0], c};
        endfunction

        task report(string what, int got, int want);
            $display("mismatch %s: got %0d expected %0d", what, got, want);
            errors++;
        endtask

        task check_result(result_t got);
            result_t w;
            if (pending.size() == 0) begin
                report("unexpected result item", 1, 0);
                return;
            end
            w = pending.pop_front();
            if (got.parse_status != w.parse_status)
                report("parse_status", got.parse_status, w.parse_status);
            if (got.route_code != w.route_code) report("route_code", got.route_code, w.route_code);
            if (got.version_minor != w.version_minor)
                report("version_minor", got.version_minor, w.version_minor);
            if (got.host_present != w.host_present)
                report("host_present", got.host_present, w.host_present);
            if (got.host_allowed != w.host_allowed)
                report("host_allowed", got.host_allowed, w.host_allowed);
            if (got.body_present != w.body_present)
                report("body_present", got.body_present, w.body_present);
            if (got.chunked_present != w.chunked_present)
                report("chunked_present", got.chunked_present, w.chunked_present);
            if (got.header_length != w.header_length)
                report("header_length", got.header_length, w.header_length);
        endtask
    endclass
endpackage

// ----- bench/testbench.sv -----
module testbench;
    import hrp_pkg::*;
    import hrp_tb_pkg::*;

    logic clk;
    logic rst_n;
    hrp_byte_if   req();
    hrp_result_if rsp();
    hrp_cfg_if    cfg();

    http_request_header_parser DUT (.clk(clk), .rst_n(rst_n), .req(req), .rsp(rsp), .cfg(cfg));

    parse_scoreboard board;
    int send_idle;
    int recv_stall;
    bit hold_off;

    initial begin
        clk = 0;
        forever #1 clk = ~clk;
    end

    initial begin
        #4000000;
        $display("simulation failed");
        $finish;
    end

    // result side: sample at rising edge, change ready at falling edge
    initial begin
        result_t r;
        rsp.ready = 0;
        forever begin
            @(posedge clk);
            if (rsp.valid && rsp.ready) begin
                r.parse_status = rsp.parse_status;
                r.route_code = rsp.route_code;
                r.version_minor = rsp.version_minor;
                r.host_present = rsp.host_present;
                r.host_allowed = rsp.host_allowed;
                r.body_present = rsp.body_present;
                r.chunked_present = rsp.chunked_present;
                r.header_length = rsp.header_length;
                board.check_result(r);
            end
            @(negedge clk);
            rsp.ready <= !hold_off && ($urandom_range(99) >= recv_stall);
        end
    end

    // valid stays high after the last byte; drain drops it
    task send_byte(byte unsigned c, bit sor);
        while ($urandom_range(99) < send_idle) begin
            req.valid <= 0;
            @(negedge clk);
        end
        req.valid <= 1;
        req.data_byte <= c;
        req.start_of_request <= sor;
        do @(posedge clk); while (!req.ready);
        board.note_byte(c, sor);
        @(negedge clk);
    endtask

    task send_text(string s, bit sor);
        for (int i = 0; i < s.len(); i++) send_byte(s[i], sor && i == 0);
    endtask

    task drain();
        req.valid <= 0;
        while (board.pending.size() != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task write_limit(logic [15:0] v);
        cfg.valid <= 1;
        cfg.max_header_bytes <= v;
        do @(posedge clk); while (!cfg.ready);
        board.write_limit(v);
        @(negedge clk);
        cfg.valid <= 0;
    endtask

    function string pick(string opts[$]);
        return opts[$urandom_range(opts.size() - 1)];
    endfunction

    function string mix_case(string s);
        string o;
        o = s;
        for (int i = 0; i < s.len(); i++)
            if ($urandom_range(1) && s[i] >= "a" && s[i] <= "z") o[i] = s[i] - 8'd32;
        return o;
    endfunction

    function string noise(int n);
        string o;
        o = "";
        for (int i = 0; i < n; i++) o = {o, string'(byte'($urandom_range(255)))};
        return o;
    endfunction

    function string pad();
        return pick('{"", "", " ", "\t", "  "});
    endfunction

    // mostly well-formed request with random content; sometimes broken
    function string make_request();
        string s;
        int lines;
        s = {pick('{"GET", "POST", "X", "G\tT", ""}), pick('{" ", " ", " ", "  "}),
             pick('{"/", "/app.js", "/style.css", "/api/v1/health", "/api/v1/snapshot",
                    "/api/v1/events", "/x", "/app.j", "/api/v1/snapshotx", "",
                    "/aaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaa"}),
             " ", pick('{"HTTP/1.0", "HTTP/1.1", "HTTP/1.1", "HTTP/2.0", "HTTP/1.1 x"}),
             pick('{"\r\n", "\r\n", "\r\n", "\n"})};
        lines = $urandom_range(4);
        for (int i = 0; i < lines; i++) begin
            case ($urandom_range(6))
                0, 1: s = {s, mix_case("host"), ":", pad(), mix_case(pick('{"localhost",
                          "127.0.0.1:32123", "localhost:32123", "127.0.0.1", "evil",
                          "local host", "localhost:1"})), pad(), "\r\n"};
                2: s = {s, mix_case("content-length"), ":", pad(),
                        pick('{"0", "00", "12", "", "0 0"}), pad(), "\r\n"};
                3: s = {s, mix_case("transfer-encoding"), ":", pad(),
                        mix_case(pick('{"chunked", "gzip, chunked", "cchunked", "chunk", ""})),
                        pad(), "\r\n"};
                4: s = {s, "X-A:", noise($urandom_range(5)), "\r\n"};
                5: s = {s, "NoColon\r\n"};
                default: s = {s, "hostx: a\r\n"};
            endcase
        end
        if ($urandom_range(9) == 0) s = {s, noise($urandom_range(8))};
        return {s, "\r\n"};
    endfunction

    task run_requests(int n);
        string s;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(15) == 0) send_text(noise($urandom_range(1, 30)), 1);
            else begin
                s = make_request();
                if ($urandom_range(19) == 0) s = s.substr(0, s.len() / 2);
                send_text(s, 1);
            end
            if ($urandom_range(7) == 0) send_text(noise($urandom_range(1, 5)), 0);
        end
    endtask

    initial begin
        board = new();
        rst_n = 0;
        req.valid = 0;
        req.data_byte = 0;
        req.start_of_request = 0;
        cfg.valid = 0;
        cfg.max_header_bytes = 0;
        send_idle = 0;
        recv_stall = 0;
        hold_off = 0;
        repeat (7) @(negedge clk);
        rst_n = 1;
        @(negedge clk);

        // directed: ignored bytes, each route, versions, header cases
        send_text("ab", 0);
        send_text("GET / HTTP/1.0\r\n\r\n", 1);
        send_text("GET /app.js HTTP/1.1\r\nHOST: LocalHost:32123 \r\n\r\n", 1);
        send_text("PUT /style.css HTTP/1.1\r\nContent-Length:\t0\r\n"
                  , 1);
        send_text("Transfer-Encoding: gzip,Chunked\r\n\r\n", 0);
        send_text("GET /api/v1/health HTTP/1.1\r\nHost: 10.0.0.1\r\n\r\n", 1);
        send_text("GET /api/v1/snapshot HTTP/1.1\r\nContent-Length: 5\r\n\r\n", 1);
        send_text("GET /api/v1/ev", 1);
        send_text("GET /api/v1/events HTTP/1.0\r\nbad line\r\n\r\n", 1);
        send_text("GET\r/ HTTP/1.1\r\n\r\n", 1);
        send_byte(8'hFF, 0);
        send_byte(8'h00, 1);
        drain();

        // tiny limits: over-limit requests refused, a request that fits exactly is parsed
        write_limit(16'd0);
        send_text("GET / HTTP/1.1\r\n\r\n", 1);
        drain();
        write_limit(16'd18);
        send_text("GET / HTTP/1.1\r\n\r\n", 1);
        send_text("GET / HTTP/1.10\r\n\r\n", 1);
        drain();
        write_limit(16'hFFFF);
        run_requests(2);
        drain();
        write_limit(16'd40);
        send_idle = 84;
        run_requests(3);
        drain();
        write_limit(16'd8192);
        send_idle = 0;
        recv_stall = 84;
        run_requests(3);
        drain();
        send_idle = 17;
        recv_stall = 17;
        run_requests(3);
        drain();

        // long receiver hold-off while requests keep coming
        send_idle = 0;
        recv_stall = 0;
        hold_off = 1;
        fork
            begin
                repeat (400) @(negedge clk);
                hold_off = 0;
            end
            run_requests(6);
        join
        drain();
        write_limit(16'd4);
        run_requests(1);
        drain();
        write_limit(16'd100);
        run_requests(3);
        drain();

        repeat (10) @(negedge clk);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
